// ----- sv/booth_multiply_restoring_divide_assert.svh -----
// Assertion macros for the multiply/divide unit.
// Every assertion samples on the rising clock edge and is disabled while reset is asserted.
`ifndef BOOTH_MULTIPLY_RESTORING_DIVIDE_ASSERT_SVH
`define BOOTH_MULTIPLY_RESTORING_DIVIDE_ASSERT_SVH

// Same-cycle implication.
`define BMRD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BMRD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bmrd_pkg.sv -----
package bmrd_pkg;

    localparam int W = 32;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // Booth recoding of {q[0], q[-1]}
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

    typedef struct packed {
        logic               op;
        logic signed [31:0] multiplier;
        logic signed [31:0] multiplicand;
        logic        [63:0] dividend;
        logic        [31:0] divisor;
    } in_t;

    typedef struct packed {
        logic signed [63:0] product;
        logic        [31:0] quotient;
        logic        [31:0] remainder;
        logic               divide_overflow;
    } out_t;

    // State carried from cell to cell. Multiply: acc/low/bit_m1 are the Booth
    // register, opnd the multiplicand. Divide: acc[W-1:0] is the partial remainder,
    // low the dividend low half that turns into the quotient, opnd the divisor.
    typedef struct packed {
        logic           valid;
        logic           op;
        logic           ovf;
        logic [W:0]     acc;
        logic [W-1:0]   low;
        logic           bit_m1;
        logic [W-1:0]   opnd;
    } stage_t;

endpackage

// ----- sv/bmrd_cell.sv -----
module bmrd_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  bmrd_pkg::stage_t  stage_in,
    output bmrd_pkg::stage_t  stage_out
);

    logic                       valid_reg;
    bmrd_pkg::stage_t           data_reg;
    bmrd_pkg::stage_t           data_next;
    logic [1:0]                 booth_sel;
    logic [bmrd_pkg::W:0]       sum;
    logic [bmrd_pkg::W:0]       opnd_ext;
    logic [bmrd_pkg::W:0]       wide;
    logic [bmrd_pkg::W+1:0]     diff;

    always_comb begin
        data_next = stage_in;
        booth_sel = {stage_in.low[0], stage_in.bit_m1};
        opnd_ext  = {stage_in.opnd[bmrd_pkg::W-1], stage_in.opnd};
        wide      = {stage_in.acc[bmrd_pkg::W-1:0], stage_in.low[bmrd_pkg::W-1]};
        diff      = {1'b0, wide} - {2'b00, stage_in.opnd};
        sum       = stage_in.acc;

        if (stage_in.op == bmrd_pkg::OP_MUL) begin
            case (booth_sel)
                bmrd_pkg::BOOTH_ADD: sum = stage_in.acc + opnd_ext;
                bmrd_pkg::BOOTH_SUB: sum = stage_in.acc - opnd_ext;
                default:             sum = stage_in.acc;
            endcase
            // arithmetic shift right of {acc, low, bit_m1}
            data_next.acc    = {sum[bmrd_pkg::W], sum[bmrd_pkg::W:1]};
            data_next.low    = {sum[0], stage_in.low[bmrd_pkg::W-1:1]};
            data_next.bit_m1 = stage_in.low[0];
        end else begin
            // trial subtract on the full W+1 bit shifted remainder
            if (!diff[bmrd_pkg::W+1]) begin
                data_next.acc = {1'b0, diff[bmrd_pkg::W-1:0]};
                data_next.low = {stage_in.low[bmrd_pkg::W-2:0], 1'b1};
            end else begin
                data_next.acc = {1'b0, wide[bmrd_pkg::W-1:0]};
                data_next.low = {stage_in.low[bmrd_pkg::W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// ----- sv/booth_multiply_restoring_divide.sv -----
// Multiply/divide unit: signed radix-2 Booth multiply (op 0) giving a 64-bit
// product, and unsigned restoring divide (op 1) of a 64-bit dividend by a 32-bit
// divisor giving quotient, remainder and an overflow flag (divisor zero or
// dividend high half not below the divisor). Each transaction runs through a
// chain of 32 cells, one Booth or restoring step per cell. It is registered in cell
// 0 when accepted and moves through each cell register in order; m_valid rises
// once it reaches the last cell. While the chain is not held, a new transaction
// can be accepted every cycle. The last cell is the output register. When it holds a
// result that is not taken, the whole chain holds and s_ready is low.
module booth_multiply_restoring_divide (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bmrd_pkg::in_t   s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output bmrd_pkg::out_t  m_payload
);

    bmrd_pkg::stage_t                   chain [0:bmrd_pkg::W];
    bmrd_pkg::stage_t                   last;
    logic                               advance;
    logic [bmrd_pkg::W-1:0]             div_hi;
    logic [bmrd_pkg::W-1:0]             div_d;
    logic signed [2*bmrd_pkg::W-1:0]    prod_w;

    assign last    = chain[bmrd_pkg::W];
    assign advance = !last.valid || m_ready;
    assign s_ready = advance;

    assign div_hi = s_payload.dividend[2*bmrd_pkg::W-1:bmrd_pkg::W];
    assign div_d  = s_payload.divisor[bmrd_pkg::W-1:0];

    always_comb begin
        chain[0].valid  = s_valid;
        chain[0].op     = s_payload.op;
        chain[0].bit_m1 = 1'b0;
        if (s_payload.op == bmrd_pkg::OP_MUL) begin
            chain[0].ovf  = 1'b0;
            chain[0].acc  = '0;
            chain[0].low  = s_payload.multiplier[bmrd_pkg::W-1:0];
            chain[0].opnd = s_payload.multiplicand[bmrd_pkg::W-1:0];
        end else begin
            chain[0].ovf  = (div_d == '0) || (div_hi >= div_d);
            chain[0].acc  = {1'b0, div_hi};
            chain[0].low  = s_payload.dividend[bmrd_pkg::W-1:0];
            chain[0].opnd = div_d;
        end
    end

    for (genvar i = 0; i < bmrd_pkg::W; i++) begin : g_cell
        bmrd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (advance),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    assign prod_w  = {last.acc[bmrd_pkg::W-1:0], last.low};
    assign m_valid = last.valid;

    always_comb begin
        if (last.op == bmrd_pkg::OP_MUL) begin
            m_payload.product         = 64'(prod_w);
            m_payload.quotient        = '0;
            m_payload.remainder       = '0;
            m_payload.divide_overflow = 1'b0;
        end else begin
            m_payload.product         = '0;
            m_payload.quotient        = 32'(last.low);
            m_payload.remainder       = 32'(last.acc[bmrd_pkg::W-1:0]);
            m_payload.divide_overflow = last.ovf;
        end
    end

endmodule

// ----- sv/bmrd_checker.sv -----
`include "booth_multiply_restoring_divide_assert.svh"

module bmrd_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input bmrd_pkg::out_t  m_payload
);

    `BMRD_ASSERT_NEXT(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped while stalled")
    `BMRD_ASSERT_NEXT(a_m_payload_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_payload), "result changed while stalled")
    `BMRD_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input blocked with empty output")
    `BMRD_ASSERT_SAME(a_fields_exclusive, aclk, aresetn, m_valid && (m_payload.product != '0), (m_payload.quotient == '0) && (m_payload.remainder == '0) && !m_payload.divide_overflow, "multiply result carries divide fields")

endmodule

bind booth_multiply_restoring_divide bmrd_checker u_bmrd_checker (.*);

// ----- dv/booth_multiply_restoring_divide_tb.sv -----
module booth_multiply_restoring_divide_tb;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          RANDOM_ITEMS = 1350;
    localparam int          DRAIN_CYCLES = 40;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    bmrd_pkg::in_t  s_payload = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    bmrd_pkg::out_t m_payload;

    bit          no_idle    = 1'b0;
    int          stall_left = 0;
    int unsigned cycle_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    booth_multiply_restoring_divide i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    class muldiv_scoreboard;
        bmrd_pkg::out_t predicted_outs[$];
        int unsigned    mismatches = 0;
        int unsigned    checked = 0;
        int unsigned    mul_count = 0;
        int unsigned    div_count = 0;
        int unsigned    ovf_count = 0;

        function bmrd_pkg::out_t muldiv_result(bmrd_pkg::in_t t);
            bmrd_pkg::out_t r;
            longint         a;
            longint         b;
            logic [31:0]    rem;
            logic [31:0]    quo;
            logic [32:0]    wide;
            r = '0;
            if (t.op == bmrd_pkg::OP_MUL) begin
                a = t.multiplier;
                b = t.multiplicand;
                r.product = a * b;
            end else begin
                rem = t.dividend[63:32];
                quo = t.dividend[31:0];
                r.divide_overflow = (t.divisor == 0) || (rem >= t.divisor);
                // restoring steps; trial runs on the full 33-bit shifted remainder
                for (int i = 0; i < 32; i++) begin
                    wide = {rem, quo[31]};
                    quo  = quo << 1;
                    if (wide >= {1'b0, t.divisor}) begin
                        wide   = wide - {1'b0, t.divisor};
                        quo[0] = 1'b1;
                    end
                    rem = wide[31:0];
                end
                r.quotient  = quo;
                r.remainder = rem;
            end
            return r;
        endfunction

        function void note_issue(bmrd_pkg::in_t t);
            bmrd_pkg::out_t r;
            r = muldiv_result(t);
            predicted_outs.push_back(r);
            if (t.op == bmrd_pkg::OP_MUL) mul_count++;
            else div_count++;
            if (r.divide_overflow) ovf_count++;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
            mismatches++;
        endtask

        task check_result(bmrd_pkg::out_t got);
            bmrd_pkg::out_t want;
            if (predicted_outs.size() == 0) begin
                report("unexpected transaction", got.product, '0);
                return;
            end
            want = predicted_outs.pop_front();
            if (got.product !== want.product)
                report("product", got.product, want.product);
            if (got.quotient !== want.quotient)
                report("quotient", got.quotient, want.quotient);
            if (got.remainder !== want.remainder)
                report("remainder", got.remainder, want.remainder);
            if (got.divide_overflow !== want.divide_overflow)
                report("divide_overflow", got.divide_overflow, want.divide_overflow);
            checked++;
        endtask
    endclass

    muldiv_scoreboard sb = new();

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        case ($urandom_range(3))
            0: return $urandom();
            1: begin
                v = $urandom_range(16);
                return $urandom_range(1) ? -v : v;
            end
            2: case ($urandom_range(4))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                3: return 32'h0000_0001;
                default: return 32'hffff_ffff;
            endcase
            default: begin
                v = 32'h1 << $urandom_range(31);
                return $urandom_range(1) ? ~v : v;
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_divisor();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(255, 1);
            2: return 32'h8000_0000 | $urandom();
            default: case ($urandom_range(2))
                0: return 32'h0000_0001;
                1: return 32'h8000_0000;
                default: return 32'hffff_ffff;
            endcase
        endcase
    endfunction

    function automatic bmrd_pkg::in_t rand_item();
        bmrd_pkg::in_t t;
        logic [31:0]   d;
        logic [31:0]   hi;
        int            kind;
        t.op           = $urandom_range(1) ? bmrd_pkg::OP_DIV : bmrd_pkg::OP_MUL;
        t.multiplier   = rand_operand();
        t.multiplicand = rand_operand();
        d    = rand_divisor();
        kind = $urandom_range(99);
        if (kind < 80) begin
            // quotient fits: high half below divisor
            hi = (d == 0) ? $urandom() : $urandom_range(d - 1, 0);
            if (d != 0 && $urandom_range(9) == 0) hi = d - 1;
        end else if (kind < 93) begin
            hi = $urandom_range(2) == 0 ? d : $urandom_range(32'hffff_ffff, d);
        end else begin
            d  = '0;
            hi = $urandom();
        end
        t.divisor  = d;
        t.dividend = {hi, 32'($urandom())};
        return t;
    endfunction

    function automatic bmrd_pkg::in_t mul_item(logic [31:0] a, logic [31:0] b);
        bmrd_pkg::in_t t;
        t.op           = bmrd_pkg::OP_MUL;
        t.multiplier   = a;
        t.multiplicand = b;
        t.dividend     = {32'($urandom()), 32'($urandom())};
        t.divisor      = $urandom();
        return t;
    endfunction

    function automatic bmrd_pkg::in_t div_item(logic [63:0] dd, logic [31:0] ds);
        bmrd_pkg::in_t t;
        t.op           = bmrd_pkg::OP_DIV;
        t.multiplier   = $urandom();
        t.multiplicand = $urandom();
        t.dividend     = dd;
        t.divisor      = ds;
        return t;
    endfunction

    task automatic send_item(bmrd_pkg::in_t t);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= t;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_issue(t);
    endtask

    task automatic run_directed();
        send_item(mul_item(32'h0000_0000, 32'h0000_0000));
        send_item(mul_item(32'h7fff_ffff, 32'h7fff_ffff));
        send_item(mul_item(32'h8000_0000, 32'h8000_0000));
        send_item(mul_item(32'h8000_0000, 32'h7fff_ffff));
        send_item(mul_item(32'hffff_ffff, 32'hffff_ffff));
        send_item(mul_item(32'h8000_0000, 32'hffff_ffff));
        send_item(mul_item(32'h0000_0001, 32'h8000_0000));
        send_item(mul_item(32'h1234_5678, 32'hffff_fffd));
        send_item(mul_item(32'hffff_ffff, 32'h0000_0001));
        send_item(div_item(64'h0, 32'h1));
        send_item(div_item(64'h0000_0000_0000_0007, 32'h2));
        send_item(div_item(64'h0000_0000_ffff_ffff, 32'h1));
        // partial remainder exceeds 32 bits in the trial
        send_item(div_item(64'hffff_fffe_ffff_ffff, 32'hffff_ffff));
        send_item(div_item(64'h8000_0000_0000_0000, 32'h8000_0001));
        send_item(div_item(64'h0000_0004_ffff_ffff, 32'h5));
        // overflow: high half equal to or above divisor
        send_item(div_item(64'hffff_ffff_ffff_ffff, 32'hffff_ffff));
        send_item(div_item(64'h0000_0005_0000_0000, 32'h5));
        send_item(div_item(64'hffff_ffff_0000_0000, 32'h1));
        // divide by zero
        send_item(div_item(64'h1234_5678_9abc_def0, 32'h0));
        send_item(div_item(64'h0, 32'h0));
        send_item(div_item(64'hffff_ffff_ffff_ffff, 32'h0));
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= no_idle ? 0 : pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            sb.check_result(m_payload);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d results outstanding",
                 cycle_count, sb.predicted_outs.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // every fourth stretch runs at full rate on both sides
            no_idle = ((n / 150) % 4) == 3;
            send_item(rand_item());
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;
        while (sb.predicted_outs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Ran %0d multiplies and %0d divides, %0d of them flagged as overflow",
                 sb.mul_count, sb.div_count, sb.ovf_count);
        $display("Checked %0d results, %0d mismatches, %0d cycles",
                 sb.checked, sb.mismatches, cycle_count);
        if (sb.mismatches == 0 && sb.predicted_outs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
